// ===== src/bsfd_pkg.sv =====
// Package for the byte-stuffed frame deframer.
// Holds the flag bytes, the status codes and the transaction structs.
// No dependencies.
package bsfd_pkg;

  localparam int unsigned MaxFrameBytesDef = 256;

  localparam logic [7:0] FlagExt  = 8'hF0;
  localparam logic [7:0] FlagStd  = 8'hF1;
  localparam logic [7:0] FlagStop = 8'hF2;
  localparam logic [7:0] FlagEsc  = 8'hF3;
  localparam logic [7:0] EscMask  = 8'h03;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CSUM  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_NO_STOP   = 3'd4,
    ST_NO_START  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       buffer_last;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       is_end;
    status_e    frame_status;
    logic       is_extended;
  } out_t;

endpackage

// ===== src/byte_stuffed_frame_deframer.sv =====
// Byte-stuffed frame deframer, top level.
// Hunts start flags, unstuffs escapes, checks the XOR checksum and reports status.
// Depends on bsfd_pkg.

// One raw byte is taken per clock while in_stall_o is low; its result, if
// any, appears in the output register on the next cycle.
// The throughput of one byte per cycle is set by the single pass of flag
// compares, checksum XOR and count update between the state registers and the
// output register. in_stall_o is high only while a result is held and stalled.
// A frame's content bytes come out one byte behind the input, as the last
// unstuffed byte is the checksum; each frame closes with one end transaction.
module byte_stuffed_frame_deframer
  import bsfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);
  localparam logic [CntW-1:0] CntFour = CntW'(4);

  logic            in_frame_q, in_frame_d;
  logic            frame_seen_q, frame_seen_d;
  logic            ext_q, ext_d;
  logic            esc_q, esc_d;
  logic [7:0]      xor_q, xor_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      held_q, held_d;

  logic            out_valid_q;
  out_t            out_q;

  logic            accept;
  logic            res_v;
  out_t            res;
  logic [7:0]      ub;
  logic            have_ub;
  logic [CntW-1:0] cnt_m1;
  logic [CntW+7:0] pos_ext;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_m1  = cnt_q - CntOne;
  assign pos_ext = {8'd0, cnt_m1};

  always_comb begin
    in_frame_d   = in_frame_q;
    frame_seen_d = frame_seen_q;
    ext_d        = ext_q;
    esc_d        = esc_q;
    xor_d        = xor_q;
    cnt_d        = cnt_q;
    held_d       = held_q;
    res_v        = 1'b0;
    res          = '0;
    res.is_end   = 1'b1;
    res.is_extended = ext_q;
    ub           = in_data_i.byte_in;
    have_ub      = 1'b0;

    if (!in_frame_q) begin
      if (frame_seen_q) begin
        if (in_data_i.buffer_last) frame_seen_d = 1'b0;
      end else if (in_data_i.byte_in == FlagStd || in_data_i.byte_in == FlagExt) begin
        in_frame_d = 1'b1;
        ext_d      = (in_data_i.byte_in == FlagExt);
        esc_d      = 1'b0;
        xor_d      = '0;
        cnt_d      = '0;
        held_d     = '0;
        if (in_data_i.buffer_last) begin
          res_v            = 1'b1;
          res.frame_status = ST_NO_STOP;
          res.is_extended  = (in_data_i.byte_in == FlagExt);
          in_frame_d       = 1'b0;
        end
      end else if (in_data_i.buffer_last) begin
        res_v            = 1'b1;
        res.frame_status = ST_NO_START;
        res.is_extended  = 1'b0;
      end
    end else begin
      if (esc_q) begin
        ub      = FlagExt | (in_data_i.byte_in & EscMask);
        esc_d   = 1'b0;
        have_ub = 1'b1;
      end else if (in_data_i.byte_in == FlagStop) begin
        res_v = 1'b1;
        if (cnt_q < CntTwo) begin
          res.frame_status = ST_SHORT;
        end else if (held_q != xor_q) begin
          res.frame_status = ST_BAD_CSUM;
        end else if (ext_q && cnt_q < CntFour) begin
          res.frame_status = ST_SHORT;
        end else begin
          res.frame_status = ST_OK;
        end
        in_frame_d   = 1'b0;
        esc_d        = 1'b0;
        frame_seen_d = !in_data_i.buffer_last;
      end else if (in_data_i.byte_in == FlagEsc) begin
        if (in_data_i.buffer_last) begin
          res_v            = 1'b1;
          res.frame_status = ST_NO_STOP;
          in_frame_d       = 1'b0;
          esc_d            = 1'b0;
          frame_seen_d     = 1'b0;
        end else begin
          esc_d = 1'b1;
        end
      end else begin
        have_ub = 1'b1;
      end

      if (have_ub) begin
        if (cnt_q >= CntMax) begin
          res_v            = 1'b1;
          res.frame_status = ST_OVERFLOW;
          in_frame_d       = 1'b0;
          esc_d            = 1'b0;
          frame_seen_d     = !in_data_i.buffer_last;
        end else if (in_data_i.buffer_last) begin
          res_v            = 1'b1;
          res.frame_status = ST_NO_STOP;
          in_frame_d       = 1'b0;
          esc_d            = 1'b0;
          frame_seen_d     = 1'b0;
        end else begin
          if (cnt_q != '0) begin
            res_v             = 1'b1;
            res.is_end        = 1'b0;
            res.frame_status  = ST_OK;
            res.data_byte     = held_q;
            res.byte_position = pos_ext[7:0];
            xor_d             = xor_q ^ held_q;
          end
          held_d = ub;
          cnt_d  = cnt_q + CntOne;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      frame_seen_q <= 1'b0;
      ext_q        <= 1'b0;
      esc_q        <= 1'b0;
      xor_q        <= '0;
      cnt_q        <= '0;
      held_q       <= '0;
    end else if (accept) begin
      in_frame_q   <= in_frame_d;
      frame_seen_q <= frame_seen_d;
      ext_q        <= ext_d;
      esc_q        <= esc_d;
      xor_q        <= xor_d;
      cnt_q        <= cnt_d;
      held_q       <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_v) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_v) out_q <= res;
  end

`ifndef SYNTHESIS
  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> in_frame_q) else $error("escape pending outside a frame");

  a_frame_seen_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_frame_q && frame_seen_q)) else $error("in frame while skipping buffer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax) else $error("unstuffed count beyond limit");

  a_content_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_end) |-> (out_q.frame_status == ST_OK))
    else $error("content transaction with non-zero status");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost or changed");
`endif

endmodule
